// File: sv/sae_pkg.sv
`default_nettype none
package sae_pkg;

    localparam int NUM_SETS_DEF    = 8;
    localparam int MAX_ELEMS_DEF   = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_ISECT  = 3'd1;
    localparam logic [2:0] CMD_UNION  = 3'd2;
    localparam logic [2:0] CMD_DIFF   = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [2:0]         first_set;
        logic [2:0]         second_set;
        logic [2:0]         dest_set;
        logic signed [31:0] element_value;
        logic [5:0]         read_position;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [6:0]         set_size;
        logic               was_new;
        logic [1:0]         status;
    } rsp_t;

endpackage
`default_nettype wire

// File: sv/set_algebra_engine_top.sv
`default_nettype none
// Channel  | Ports                         | Beat
// ---------+-------------------------------+---------------------------------
// command  | s_valid, s_ready, s_data      | one sae_pkg::cmd_t per command
// result   | m_valid, m_ready, m_data      | one sae_pkg::rsp_t per command
//
// One command at a time. Insert scans the set for the value before it appends it.
// The single-port element store reads one word per cycle.
// Reset clears set counts and control; element store and scratch list are not cleared.
// A result held for m_ready blocks the next command until taken.
module set_algebra_engine_top #(
    parameter int NUM_SETS    = sae_pkg::NUM_SETS_DEF,
    parameter int MAX_ELEMS   = sae_pkg::MAX_ELEMS_DEF,
    parameter int VALUE_WIDTH = sae_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire sae_pkg::cmd_t s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output sae_pkg::rsp_t      m_data
);
    localparam int EW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;   // element index
    localparam int CW = $clog2(MAX_ELEMS + 1);                      // count
    localparam int AW = $clog2(8 * MAX_ELEMS);                      // store address
    localparam int KW = CW + 1;                                     // loop counters

    // state codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_OUTER = 4'd1;   // issue read of outer element
    localparam logic [3:0] S_OWAIT = 4'd2;   // capture outer element
    localparam logic [3:0] S_INNER = 4'd3;   // issue read of inner element
    localparam logic [3:0] S_ICMP  = 4'd4;   // compare inner element
    localparam logic [3:0] S_COPYR = 4'd5;   // union: read big set element
    localparam logic [3:0] S_COPYW = 4'd6;   // union: push it into scratch
    localparam logic [3:0] S_WRRD  = 4'd7;   // read scratch for write-back
    localparam logic [3:0] S_WRWR  = 4'd8;   // write element back
    localparam logic [3:0] S_RDWT  = 4'd9;   // read command: data arrives
    localparam logic [3:0] S_DONE  = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    // set counts (8 entries, fixed by the 3-bit set fields)
    logic [CW-1:0] cnt_reg [8];

    // element store: single port, registered read
    logic [VALUE_WIDTH-1:0] store_mem [8*MAX_ELEMS];
    logic [VALUE_WIDTH-1:0] store_q;
    logic                   st_we;
    logic [AW-1:0]          st_addr;
    logic [VALUE_WIDTH-1:0] st_wdata;

    // scratch list: single port, registered read
    logic [VALUE_WIDTH-1:0] scr_mem [MAX_ELEMS];
    logic [VALUE_WIDTH-1:0] scr_q;
    logic                   sc_we;
    logic [EW-1:0]          sc_addr;
    logic [VALUE_WIDTH-1:0] sc_wdata;

    always_ff @(posedge aclk) begin
        if (st_we) begin
            store_mem[st_addr] <= st_wdata;
        end
        store_q <= store_mem[st_addr];
    end

    always_ff @(posedge aclk) begin
        if (sc_we) begin
            scr_mem[sc_addr] <= sc_wdata;
        end
        scr_q <= scr_mem[sc_addr];
    end

    logic [3:0]             state_reg, state_next;
    sae_pkg::cmd_t          cmd_reg, cmd_next;
    logic [KW-1:0]          i_reg, i_next;        // outer index
    logic [KW-1:0]          j_reg, j_next;        // inner index
    logic [CW-1:0]          scnt_reg, scnt_next;  // scratch count
    logic [VALUE_WIDTH-1:0] val_reg, val_next;    // held outer element
    logic                   over_reg, over_next;
    logic                   inner_scr_reg, inner_scr_next; // inner scan over scratch
    logic [2:0]             oset_reg, oset_next;  // outer set
    logic [2:0]             iset_reg, iset_next;  // inner set
    sae_pkg::rsp_t          rsp_reg, rsp_next;

    // helpers
    function automatic logic [CW-1:0] count_of(input logic [2:0] s,
                                               input logic [CW-1:0] c);
        count_of = (32'(s) < NUM_SETS) ? c : '0;
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [2:0] s, input logic [KW-1:0] k);
        logic [AW+2:0] a;
        a = (AW+3)'(s) * (AW+3)'(MAX_ELEMS) + (AW+3)'(k);
        addr_of = a[AW-1:0];
    endfunction

    logic [CW-1:0] na, nb, no, ni;
    logic [VALUE_WIDTH-1:0] ev;
    logic [VALUE_WIDTH-1:0] inner_q;

    always_comb begin
        na = count_of(cmd_reg.first_set, cnt_reg[cmd_reg.first_set]);
        nb = count_of(cmd_reg.second_set, cnt_reg[cmd_reg.second_set]);
        no = count_of(oset_reg, cnt_reg[oset_reg]);
        ni = inner_scr_reg ? scnt_reg : count_of(iset_reg, cnt_reg[iset_reg]);
        ev = VALUE_WIDTH'(cmd_reg.element_value);
        inner_q = inner_scr_reg ? scr_q : store_q;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign m_data  = rsp_reg;

    logic wr_cnt;
    logic [CW-1:0] wr_cnt_val;
    logic [2:0]    wr_cnt_set;

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        scnt_next      = scnt_reg;
        val_next       = val_reg;
        over_next      = over_reg;
        inner_scr_next = inner_scr_reg;
        oset_next      = oset_reg;
        iset_next      = iset_reg;
        rsp_next       = rsp_reg;
        st_we    = 1'b0;
        st_addr  = addr_of(oset_reg, i_reg);
        st_wdata = val_reg;
        sc_we    = 1'b0;
        sc_addr  = EW'(j_reg);
        sc_wdata = val_reg;
        wr_cnt     = 1'b0;
        wr_cnt_val = scnt_reg;
        wr_cnt_set = cmd_reg.dest_set;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next  = s_data;
                    i_next    = '0;
                    j_next    = '0;
                    scnt_next = '0;
                    over_next = 1'b0;
                    rsp_next  = '0;
                    state_next = S_DONE;
                    // pick loop roles per command
                    unique case (s_data.cmd) inside
                        sae_pkg::CMD_INSERT: begin
                            // inner scan of first set for the value
                            oset_next      = s_data.first_set;
                            iset_next      = s_data.first_set;
                            inner_scr_next = 1'b0;
                            state_next     = (32'(s_data.first_set) < NUM_SETS) ?
                                             S_INNER : S_DONE;
                        end
                        sae_pkg::CMD_READ: begin
                            oset_next  = s_data.first_set;
                            i_next     = KW'(s_data.read_position);
                            state_next = S_OUTER;
                        end
                        sae_pkg::CMD_ISECT, sae_pkg::CMD_DIFF: begin
                            oset_next      = s_data.first_set;
                            iset_next      = s_data.second_set;
                            inner_scr_next = 1'b0;
                            state_next     = S_OUTER;
                        end
                        sae_pkg::CMD_UNION: begin
                            inner_scr_next = 1'b1;
                            state_next     = S_COPYR;
                        end
                        default: state_next = S_DONE;
                    endcase
                    if (s_data.cmd == sae_pkg::CMD_UNION) begin
                        // larger source first; second source on a tie
                        if (count_of(s_data.first_set, cnt_reg[s_data.first_set]) >
                            count_of(s_data.second_set, cnt_reg[s_data.second_set])) begin
                            iset_next = s_data.first_set;   // big
                            oset_next = s_data.second_set;  // small
                        end else begin
                            iset_next = s_data.second_set;
                            oset_next = s_data.first_set;
                        end
                    end
                end
            end

            S_COPYR: begin
                // copy big set (iset) into scratch
                if (i_reg >= KW'(count_of(iset_reg, cnt_reg[iset_reg]))) begin
                    i_next     = '0;
                    state_next = S_OUTER;
                end else begin
                    st_addr    = addr_of(iset_reg, i_reg);
                    state_next = S_COPYW;
                end
            end

            S_COPYW: begin
                sc_we     = 1'b1;
                sc_addr   = EW'(scnt_reg);
                sc_wdata  = store_q;
                scnt_next = scnt_reg + 1'b1;
                i_next    = i_reg + 1'b1;
                state_next = S_COPYR;
            end

            S_OUTER: begin
                if (cmd_reg.cmd == sae_pkg::CMD_READ) begin
                    if (i_reg < KW'(na)) begin
                        st_addr    = addr_of(oset_reg, i_reg);
                        state_next = S_RDWT;
                    end else begin
                        rsp_next.status   = sae_pkg::ST_RANGE;
                        rsp_next.set_size = 7'(na);
                        state_next        = S_OUT;
                    end
                end else if (i_reg >= KW'(no)) begin
                    j_next     = '0;
                    state_next = S_WRRD;
                end else begin
                    st_addr    = addr_of(oset_reg, i_reg);
                    state_next = S_OWAIT;
                end
            end

            S_OWAIT: begin
                val_next   = store_q;
                j_next     = '0;
                state_next = S_INNER;
            end

            S_INNER: begin
                if (j_reg >= KW'(ni)) begin
                    // scan finished without a hit
                    if (cmd_reg.cmd == sae_pkg::CMD_INSERT) begin
                        if (no < CW'(MAX_ELEMS)) begin
                            st_we    = 1'b1;
                            st_addr  = addr_of(oset_reg, KW'(no));
                            st_wdata = ev;
                            wr_cnt   = 1'b1;
                            wr_cnt_set = oset_reg;
                            wr_cnt_val = no + 1'b1;
                            rsp_next.was_new  = 1'b1;
                            rsp_next.set_size = 7'(no + 1'b1);
                        end else begin
                            rsp_next.status   = sae_pkg::ST_FULL;
                            rsp_next.set_size = 7'(no);
                        end
                        state_next = S_OUT;
                    end else begin
                        if ((cmd_reg.cmd == sae_pkg::CMD_DIFF ||
                             cmd_reg.cmd == sae_pkg::CMD_UNION) &&
                            scnt_reg < CW'(MAX_ELEMS)) begin
                            sc_we     = 1'b1;
                            sc_addr   = EW'(scnt_reg);
                            scnt_next = scnt_reg + 1'b1;
                        end
                        if (cmd_reg.cmd == sae_pkg::CMD_UNION &&
                            scnt_reg >= CW'(MAX_ELEMS)) begin
                            // drop the rest of the small set
                            over_next  = 1'b1;
                            j_next     = '0;
                            state_next = S_WRRD;
                        end else begin
                            i_next     = i_reg + 1'b1;
                            state_next = S_OUTER;
                        end
                    end
                end else begin
                    st_addr    = addr_of(iset_reg, j_reg);
                    sc_addr    = EW'(j_reg);
                    state_next = S_ICMP;
                end
            end

            S_ICMP: begin
                if (cmd_reg.cmd == sae_pkg::CMD_INSERT) begin
                    if (store_q == ev) begin
                        rsp_next.set_size = 7'(no);
                        state_next        = S_OUT;
                    end else begin
                        j_next     = j_reg + 1'b1;
                        state_next = S_INNER;
                    end
                end else if (inner_q == val_reg) begin
                    // hit: intersect keeps, others skip
                    if (cmd_reg.cmd == sae_pkg::CMD_ISECT && scnt_reg < CW'(MAX_ELEMS)) begin
                        sc_we     = 1'b1;
                        sc_addr   = EW'(scnt_reg);
                        scnt_next = scnt_reg + 1'b1;
                    end
                    i_next     = i_reg + 1'b1;
                    state_next = S_OUTER;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_INNER;
                end
            end

            S_WRRD: begin
                if (32'(cmd_reg.dest_set) >= NUM_SETS) begin
                    rsp_next.status = over_reg ? sae_pkg::ST_FULL : sae_pkg::ST_OK;
                    state_next = S_OUT;
                end else if (j_reg >= KW'(scnt_reg)) begin
                    wr_cnt            = 1'b1;
                    rsp_next.set_size = 7'(scnt_reg);
                    rsp_next.status   = over_reg ? sae_pkg::ST_FULL : sae_pkg::ST_OK;
                    state_next        = S_OUT;
                end else begin
                    sc_addr    = EW'(j_reg);
                    state_next = S_WRWR;
                end
            end

            S_WRWR: begin
                st_we    = 1'b1;
                st_addr  = addr_of(cmd_reg.dest_set, j_reg);
                st_wdata = scr_q;
                j_next   = j_reg + 1'b1;
                state_next = S_WRRD;
            end

            S_RDWT: begin
                rsp_next.read_value = 32'(signed'(store_q));
                rsp_next.set_size   = 7'(na);
                state_next          = S_OUT;
            end

            S_DONE: begin
                state_next = S_OUT;
            end

            S_OUT: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            for (int k = 0; k < 8; k++) begin
                cnt_reg[k] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (wr_cnt) begin
                cnt_reg[wr_cnt_set] <= wr_cnt_val;
            end
        end
    end

    // payload and loop registers hold without reset
    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        scnt_reg      <= scnt_next;
        val_reg       <= val_next;
        over_reg      <= over_next;
        inner_scr_reg <= inner_scr_next;
        oset_reg      <= oset_next;
        iset_reg      <= iset_next;
        rsp_reg       <= rsp_next;
    end

endmodule
`default_nettype wire

// File: tb/sv/tb_set_algebra_engine_top.sv
`default_nettype none
module tb_set_algebra_engine_top;

    localparam int NSETS    = sae_pkg::NUM_SETS_DEF;
    localparam int CAP      = sae_pkg::MAX_ELEMS_DEF;
    localparam longint CYCLE_LIMIT = 10000000;

    logic           aclk;
    logic           aresetn;
    logic           s_valid;
    logic           s_ready;
    sae_pkg::cmd_t  s_data;
    logic           m_valid;
    logic           m_ready;
    sae_pkg::rsp_t  m_data;

    set_algebra_engine_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Shadow copy of the set bank used to work out each expected response.
    logic [31:0]   bank_elems [NSETS][$];
    sae_pkg::rsp_t rsp_queue [$];
    int            error_count;
    longint        cycle_count;
    bit            hold_off_rx;
    int            hold_off_len;
    bit            gaps_on;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Abort the run at a generous cycle limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic bit bank_has(input int s, input logic [31:0] v);
        if (s >= NSETS) return 1'b0;
        foreach (bank_elems[s][k]) if (bank_elems[s][k] == v) return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit queue_has(input logic [31:0] q [$], input logic [31:0] v);
        foreach (q[k]) if (q[k] == v) return 1'b1;
        return 1'b0;
    endfunction

    // Apply one command to the shadow bank and return the response it yields.
    function automatic sae_pkg::rsp_t apply_command(input sae_pkg::cmd_t c);
        sae_pkg::rsp_t r;
        logic [31:0] work [$];
        int a, b, d, big, sml;
        bit over;
        r = '0;
        a = c.first_set;
        b = c.second_set;
        d = c.dest_set;
        over = 1'b0;
        case (c.cmd) inside
            sae_pkg::CMD_INSERT: begin
                if (a < NSETS) begin
                    if (!bank_has(a, c.element_value)) begin
                        if (bank_elems[a].size() < CAP) begin
                            bank_elems[a].push_back(c.element_value);
                            r.was_new = 1'b1;
                        end else begin
                            r.status = sae_pkg::ST_FULL;
                        end
                    end
                    r.set_size = 7'(bank_elems[a].size());
                end
            end
            sae_pkg::CMD_READ: begin
                r.set_size = (a < NSETS) ? 7'(bank_elems[a].size()) : 7'd0;
                if (c.read_position < r.set_size) r.read_value = bank_elems[a][c.read_position];
                else r.status = sae_pkg::ST_RANGE;
            end
            sae_pkg::CMD_ISECT, sae_pkg::CMD_DIFF: begin
                foreach (bank_elems[a][k])
                    if (bank_has(b, bank_elems[a][k]) == (c.cmd == sae_pkg::CMD_ISECT))
                        work.push_back(bank_elems[a][k]);
            end
            sae_pkg::CMD_UNION: begin
                big = (bank_elems[a].size() > bank_elems[b].size()) ? a : b;
                sml = (big == a && a != b) ? b : a;
                if (bank_elems[a].size() <= bank_elems[b].size()) begin
                    big = b;
                    sml = a;
                end
                work = bank_elems[big];
                foreach (bank_elems[sml][k]) begin
                    if (!over && !queue_has(work, bank_elems[sml][k])) begin
                        if (work.size() >= CAP) over = 1'b1;
                        else work.push_back(bank_elems[sml][k]);
                    end
                end
                if (over) r.status = sae_pkg::ST_FULL;
            end
            default: ;
        endcase
        if (c.cmd inside {sae_pkg::CMD_ISECT, sae_pkg::CMD_UNION, sae_pkg::CMD_DIFF} &&
            d < NSETS) begin
            bank_elems[d] = work;
            r.set_size = 7'(work.size());
        end
        return r;
    endfunction

    function automatic int gap_len();
        if (!gaps_on) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 1) == 0) return 0;
        return $urandom_range(1, 3);
    endfunction

    // Offer one command beat, hold it until accepted, then log its response.
    task automatic send_command(input sae_pkg::cmd_t c);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        do @(posedge aclk); while (!s_ready);
        rsp_queue.push_back(apply_command(c));
    endtask

    // Take result beats with random stalls and a long hold-off when asked.
    initial begin
        int g;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_rx) begin
                m_ready <= 1'b0;
                repeat (hold_off_len) @(posedge aclk);
                hold_off_rx = 1'b0;
            end
            g = gap_len();
            if (g > 0) begin
                m_ready <= 1'b0;
                repeat (g - 1) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Compare each accepted result beat with the oldest expected response.
    always @(posedge aclk) begin
        sae_pkg::rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (rsp_queue.size() == 0) begin
                $error("result beat with nothing expected");
                error_count++;
            end else begin
                want = rsp_queue.pop_front();
                if (m_data.read_value !== want.read_value) begin
                    $error("read_value exp %0d got %0d", want.read_value, m_data.read_value);
                    error_count++;
                end
                if (m_data.set_size !== want.set_size) begin
                    $error("set_size exp %0d got %0d", want.set_size, m_data.set_size);
                    error_count++;
                end
                if (m_data.was_new !== want.was_new) begin
                    $error("was_new exp %0d got %0d", want.was_new, m_data.was_new);
                    error_count++;
                end
                if (m_data.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, m_data.status);
                    error_count++;
                end
            end
        end
    end

    function automatic sae_pkg::cmd_t make_cmd(input logic [2:0] op, input int a, input int b,
                                               input int d, input logic [31:0] v,
                                               input int p);
        sae_pkg::cmd_t c;
        c.cmd           = op;
        c.first_set     = 3'(a);
        c.second_set    = 3'(b);
        c.dest_set      = 3'(d);
        c.element_value = v;
        c.read_position = 6'(p);
        return c;
    endfunction

    // Drop valid and wait until every expected result has come back.
    task automatic wait_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (rsp_queue.size() != 0) @(posedge aclk);
    endtask

    // Directed: extremes, every operation, full set, union overflow, aliasing.
    task automatic test_directed();
        send_command(make_cmd(sae_pkg::CMD_READ, 0, 0, 0, 0, 0));
        send_command(make_cmd(sae_pkg::CMD_INSERT, 0, 7, 7, 32'h8000_0000, 63));
        send_command(make_cmd(sae_pkg::CMD_INSERT, 0, 0, 0, 32'h7fff_ffff, 0));
        send_command(make_cmd(sae_pkg::CMD_INSERT, 0, 0, 0, 32'h8000_0000, 0));
        send_command(make_cmd(sae_pkg::CMD_INSERT, 1, 0, 0, 32'hffff_ffff, 0));
        send_command(make_cmd(sae_pkg::CMD_INSERT, 1, 0, 0, 32'h7fff_ffff, 0));
        send_command(make_cmd(sae_pkg::CMD_READ, 0, 0, 0, 0, 1));
        send_command(make_cmd(sae_pkg::CMD_READ, 0, 0, 0, 0, 2));
        send_command(make_cmd(sae_pkg::CMD_READ, 0, 0, 0, 0, 63));
        send_command(make_cmd(sae_pkg::CMD_ISECT, 0, 1, 2, 0, 0));
        send_command(make_cmd(sae_pkg::CMD_UNION, 0, 1, 3, 0, 0));
        send_command(make_cmd(sae_pkg::CMD_DIFF, 0, 1, 0, 0, 0));
        send_command(make_cmd(sae_pkg::CMD_UNION, 1, 1, 1, 0, 0));
        send_command(make_cmd(3'd5, 7, 7, 7, 32'hffff_ffff, 63));
        send_command(make_cmd(3'd7, 0, 0, 0, 0, 0));
        // Fill set 4 to capacity, then insert past it.
        for (int k = 0; k < CAP; k++)
            send_command(make_cmd(sae_pkg::CMD_INSERT, 4, 0, 0, k, 0));
        send_command(make_cmd(sae_pkg::CMD_INSERT, 4, 0, 0, 32'd1000, 0));
        send_command(make_cmd(sae_pkg::CMD_INSERT, 4, 0, 0, 32'd5, 0));
        send_command(make_cmd(sae_pkg::CMD_READ, 4, 0, 0, 0, 63));
        // Disjoint full-ish union truncates.
        for (int k = 0; k < 8; k++)
            send_command(make_cmd(sae_pkg::CMD_INSERT, 5, 0, 0, -k - 1, 0));
        send_command(make_cmd(sae_pkg::CMD_UNION, 5, 4, 6, 0, 0));
        send_command(make_cmd(sae_pkg::CMD_ISECT, 4, 6, 6, 0, 0));
        send_command(make_cmd(sae_pkg::CMD_DIFF, 4, 4, 4, 0, 0));
        wait_drain();
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 15);
            1: return -$urandom_range(1, 8);
            default: return $urandom();
        endcase
    endfunction

    // Random: inserts most often, many of small values so sets overlap, plus all commands.
    task automatic test_random(input int n);
        sae_pkg::cmd_t c;
        for (int i = 0; i < n; i++) begin
            c.first_set     = 3'($urandom_range(0, 7));
            c.second_set    = 3'($urandom_range(0, 7));
            c.dest_set      = 3'($urandom_range(0, 7));
            c.read_position = 6'($urandom_range(0, 63));
            case ($urandom_range(0, 9))
                0, 1, 2, 3: c.cmd = sae_pkg::CMD_INSERT;
                4: c.cmd = sae_pkg::CMD_ISECT;
                5: c.cmd = sae_pkg::CMD_UNION;
                6: c.cmd = sae_pkg::CMD_DIFF;
                7, 8: c.cmd = sae_pkg::CMD_READ;
                default: c.cmd = 3'($urandom_range(0, 7));
            endcase
            c.element_value = rand_value();
            if ($urandom_range(0, 1)) c.read_position = 6'($urandom_range(0, 10));
            send_command(c);
        end
    endtask

    // Stall the result side for a long stretch while commands keep coming.
    task automatic test_backpressure();
        hold_off_len = 300;
        hold_off_rx  = 1'b1;
        test_random(10);
        wait_drain();
    endtask

    // Back-to-back traffic with no gaps on either side.
    task automatic test_streaming();
        gaps_on = 1'b0;
        test_random(10);
        wait_drain();
        gaps_on = 1'b1;
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        error_count = 0;
        cycle_count = 0;
        hold_off_rx = 1'b0;
        hold_off_len = 0;
        gaps_on = 1'b1;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(20);
        wait_drain();
        test_backpressure();
        test_streaming();
        test_random(8);
        wait_drain();
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: set_algebra_engine_top.f
sv/sae_pkg.sv
sv/set_algebra_engine_top.sv
tb/sv/tb_set_algebra_engine_top.sv
